[sv/lexicographic_permutation_stepper_macros.svh]
// Assertion macros used by the permutation stepper sequencer.
`ifndef LEXICOGRAPHIC_PERMUTATION_STEPPER_MACROS_SVH
`define LEXICOGRAPHIC_PERMUTATION_STEPPER_MACROS_SVH

// Checks that the antecedent implies the consequent in the same cycle.
`define LPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the antecedent implies the consequent in the following cycle.
`define LPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/lps_pkg.sv]
// Package with constants and types shared by the permutation stepper modules.
`timescale 1ns / 1ps
package lps_pkg;
   localparam int ENTRY_W = 4;
   localparam int DEFAULT_MAX_COUNT = 16;
   localparam int OP_W = 2;
   localparam int STEP_W = 16;
   localparam int COUNT_W = 5;
   localparam int PERM_W = 64;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd11;

   localparam logic [OP_W-1:0] OP_RESET = 2'd0;
   localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
   localparam logic [OP_W-1:0] OP_JUMP = 2'd2;

   typedef struct packed {
      logic wr_en;
      logic load_identity;
   } store_cmd_type;

   typedef struct packed {
      logic idle;
      logic done;
      logic has_next;
   } seq_status_type;
endpackage

[sv/lps_store.sv]
// Permutation store with one read port, one write port and an identity load.
`timescale 1ns / 1ps
module lps_store
   import lps_pkg::*;
#(
   parameter int MAX_COUNT = DEFAULT_MAX_COUNT,
   localparam int IDX_W = $clog2(MAX_COUNT)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  store_cmd_type                cmd,
   input  logic [IDX_W-1:0]             rd_addr,
   input  logic [IDX_W-1:0]             wr_addr,
   input  logic [ENTRY_W-1:0]           wr_data,
   output logic [ENTRY_W-1:0]           rd_data,
   output logic [MAX_COUNT*ENTRY_W-1:0] entries
);
   logic [ENTRY_W-1:0] entries_ff [MAX_COUNT];

   always_ff @(posedge clock) begin
      if (reset || cmd.load_identity) begin
         for (int i = 0; i < MAX_COUNT; i++) begin
            entries_ff[i] <= ENTRY_W'(i);
         end
      end else if (cmd.wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = entries_ff[rd_addr];

   always_comb begin
      for (int i = 0; i < MAX_COUNT; i++) begin
         entries[i*ENTRY_W +: ENTRY_W] = entries_ff[i];
      end
   end
endmodule

[sv/lps_sequencer.sv]
// Sequencer that steps the store with one shared entry comparator.
`timescale 1ns / 1ps
module lps_sequencer
   import lps_pkg::*;
#(
   parameter int MAX_COUNT = DEFAULT_MAX_COUNT,
   localparam int IDX_W = $clog2(MAX_COUNT),
   localparam int CNT_W = $clog2(MAX_COUNT + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [OP_W-1:0]    op,
   input  logic [STEP_W-1:0]  step_count,
   input  logic [CNT_W-1:0]   count,
   input  logic               out_free,
   input  logic [ENTRY_W-1:0] rd_data,
   output store_cmd_type      cmd,
   output logic [IDX_W-1:0]   rd_addr,
   output logic [IDX_W-1:0]   wr_addr,
   output logic [ENTRY_W-1:0] wr_data,
   output seq_status_type     status
);
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADV_START,
      ST_SCAN_PIVOT,
      ST_SCAN_K,
      ST_SWAP_K,
      ST_SWAP_P,
      ST_REV_A,
      ST_REV_B,
      ST_REV_C,
      ST_STEP_END,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   pl_ff, pl_in;
   logic [IDX_W-1:0]   lo_ff, lo_in;
   logic [IDX_W-1:0]   hi_ff, hi_in;
   logic [ENTRY_W-1:0] hold_a_ff, hold_a_in;
   logic [ENTRY_W-1:0] hold_b_ff, hold_b_in;
   logic [ENTRY_W-1:0] pv_ff, pv_in;
   logic               flag_ff, flag_in;
   logic [ENTRY_W-1:0] cmp_a;
   logic [ENTRY_W-1:0] cmp_b;
   logic               cmp_lt;
   logic [IDX_W-1:0]   last_idx;

   assign last_idx = IDX_W'(count - CNT_W'(1));
   assign cmp_lt = cmp_a < cmp_b;

   always_comb begin
      state_in = state_ff;
      steps_in = steps_ff;
      idx_in = idx_ff;
      pl_in = pl_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      hold_a_in = hold_a_ff;
      hold_b_in = hold_b_ff;
      pv_in = pv_ff;
      flag_in = flag_ff;
      cmd = '0;
      rd_addr = idx_ff;
      wr_addr = lo_ff;
      wr_data = hold_b_ff;
      cmp_a = rd_data;
      cmp_b = hold_a_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               flag_in = 1'b0;
               case (op)
                  OP_RESET: begin
                     cmd.load_identity = 1'b1;
                     state_in = ST_DONE;
                  end
                  OP_ADVANCE: begin
                     steps_in = STEP_W'(1);
                     state_in = ST_ADV_START;
                  end
                  OP_JUMP: begin
                     cmd.load_identity = 1'b1;
                     steps_in = step_count;
                     state_in = (step_count == '0) ? ST_DONE : ST_ADV_START;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_ADV_START: begin
            rd_addr = last_idx;
            if (count <= CNT_W'(1)) begin
               flag_in = 1'b0;
               state_in = ST_STEP_END;
            end else begin
               hold_a_in = rd_data;
               idx_in = IDX_W'(count - CNT_W'(2));
               state_in = ST_SCAN_PIVOT;
            end
         end
         ST_SCAN_PIVOT: begin
            rd_addr = idx_ff;
            if (cmp_lt) begin
               pl_in = idx_ff;
               pv_in = rd_data;
               idx_in = last_idx;
               state_in = ST_SCAN_K;
            end else if (idx_ff == '0) begin
               lo_in = '0;
               hi_in = last_idx;
               flag_in = 1'b0;
               state_in = ST_REV_A;
            end else begin
               hold_a_in = rd_data;
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         ST_SCAN_K: begin
            rd_addr = idx_ff;
            cmp_a = pv_ff;
            cmp_b = rd_data;
            if (cmp_lt) begin
               hold_b_in = rd_data;
               state_in = ST_SWAP_K;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         ST_SWAP_K: begin
            cmd.wr_en = 1'b1;
            wr_addr = idx_ff;
            wr_data = pv_ff;
            state_in = ST_SWAP_P;
         end
         ST_SWAP_P: begin
            cmd.wr_en = 1'b1;
            wr_addr = pl_ff;
            wr_data = hold_b_ff;
            lo_in = pl_ff + IDX_W'(1);
            hi_in = last_idx;
            flag_in = 1'b1;
            state_in = ST_REV_A;
         end
         ST_REV_A: begin
            rd_addr = lo_ff;
            if (lo_ff < hi_ff) begin
               hold_a_in = rd_data;
               state_in = ST_REV_B;
            end else begin
               state_in = ST_STEP_END;
            end
         end
         ST_REV_B: begin
            rd_addr = hi_ff;
            hold_b_in = rd_data;
            cmd.wr_en = 1'b1;
            wr_addr = hi_ff;
            wr_data = hold_a_ff;
            state_in = ST_REV_C;
         end
         ST_REV_C: begin
            cmd.wr_en = 1'b1;
            wr_addr = lo_ff;
            wr_data = hold_b_ff;
            lo_in = lo_ff + IDX_W'(1);
            hi_in = hi_ff - IDX_W'(1);
            state_in = ST_REV_A;
         end
         ST_STEP_END: begin
            if (steps_ff == STEP_W'(1)) begin
               state_in = ST_DONE;
            end else begin
               steps_in = steps_ff - STEP_W'(1);
               state_in = ST_ADV_START;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         flag_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         flag_ff <= flag_in;
      end
      steps_ff <= steps_in;
      idx_ff <= idx_in;
      pl_ff <= pl_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      hold_a_ff <= hold_a_in;
      hold_b_ff <= hold_b_in;
      pv_ff <= pv_in;
   end

   assign status.idle = (state_ff == ST_IDLE);
   assign status.done = (state_ff == ST_DONE);
   assign status.has_next = flag_ff;

`include "lexicographic_permutation_stepper_macros.svh"

   `LPS_ASSERT_SAME(a_scan_k_right_of_pivot, clock, reset, state_ff == ST_SCAN_K, idx_ff > pl_ff, "Successor scan passed the pivot.")
   `LPS_ASSERT_SAME(a_reverse_ordered, clock, reset, state_ff == ST_REV_B, lo_ff < hi_ff, "Reversal swap with crossed bounds.")
   `LPS_ASSERT_NEXT(a_start_leaves_idle, clock, reset, status.idle && start, !status.idle, "Accepted request did not start work.")
endmodule

[sv/lexicographic_permutation_stepper.sv]
// Top level of the lexicographic permutation stepper.
//
// Each request runs one operation on a store of MAX_COUNT 4-bit entries and
// returns the first element_count entries (capped at MAX_COUNT) packed into
// rsp_permutation, with rsp_has_next telling whether the last advance found a
// successor. A reset request loads the identity and goes straight to the done
// state. In an advance, the pivot and successor scans read one entry per
// cycle through the single store read port into the shared entry comparator,
// and each swap of the suffix reversal passes through the REV_A, REV_B and
// REV_C states. A jump loads the identity and then runs step_count advances.
// The block takes no request and no csr write while an operation is in
// progress; the finished result sits in an output register, so the next
// request is taken while it waits.
`timescale 1ns / 1ps
module lexicographic_permutation_stepper
   import lps_pkg::*;
#(
   parameter int MAX_COUNT = DEFAULT_MAX_COUNT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [STEP_W-1:0]  req_step_count,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [PERM_W-1:0]  rsp_permutation,
   output logic               rsp_has_next,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_element_count
);
   localparam int IDX_W = $clog2(MAX_COUNT);
   localparam int CNT_W = $clog2(MAX_COUNT + 1);

   logic [COUNT_W-1:0]           element_count_ff;
   logic [CNT_W-1:0]             count_eff;
   logic                         rsp_valid_ff;
   logic [PERM_W-1:0]            rsp_permutation_ff, rsp_permutation_in;
   logic                         rsp_has_next_ff;
   logic                         out_free;
   logic                         out_load;
   store_cmd_type                cmd;
   seq_status_type               status;
   logic [IDX_W-1:0]             rd_addr;
   logic [IDX_W-1:0]             wr_addr;
   logic [ENTRY_W-1:0]           wr_data;
   logic [ENTRY_W-1:0]           rd_data;
   logic [MAX_COUNT*ENTRY_W-1:0] entries;

   assign count_eff = (element_count_ff > COUNT_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT)
                                                             : CNT_W'(element_count_ff);
   assign req_stall = !status.idle;
   assign csr_ready = status.idle;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = status.done && out_free;

   lps_store #(
      .MAX_COUNT(MAX_COUNT)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .rd_addr(rd_addr),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_data(rd_data),
      .entries(entries)
   );

   lps_sequencer #(
      .MAX_COUNT(MAX_COUNT)
   ) u_sequencer (
      .clock(clock),
      .reset(reset),
      .start(req_valid),
      .op(req_operation),
      .step_count(req_step_count),
      .count(count_eff),
      .out_free(out_free),
      .rd_data(rd_data),
      .cmd(cmd),
      .rd_addr(rd_addr),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .status(status)
   );

   always_comb begin
      rsp_permutation_in = '0;
      for (int i = 0; i < MAX_COUNT; i++) begin
         if (CNT_W'(i) < count_eff) begin
            rsp_permutation_in[i*ENTRY_W +: ENTRY_W] = entries[i*ENTRY_W +: ENTRY_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         element_count_ff <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            element_count_ff <= csr_element_count;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (out_load) begin
         rsp_permutation_ff <= rsp_permutation_in;
         rsp_has_next_ff <= status.has_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_permutation = rsp_permutation_ff;
   assign rsp_has_next = rsp_has_next_ff;
endmodule
